/* rtl/smseq_pkg.sv */
`timescale 1ns / 1ps
package smseq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CURVE_LEN   = 100;

    localparam int QA_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int CA_W   = (CURVE_LEN > 1) ? $clog2(CURVE_LEN) : 1;
    localparam int DIVD_W = 16 + $clog2(CURVE_LEN);
    localparam int DCNT_W = $clog2(DIVD_W + 1);
    localparam int QENT_W = 3 + 16 + 16;

    // Command codes.
    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_RUN    = 3'd1;
    localparam logic [2:0] CMD_CLEAR  = 3'd2;
    localparam logic [2:0] CMD_CURVE  = 3'd3;
    localparam logic [2:0] CMD_MANUAL = 3'd4;
    localparam logic [2:0] CMD_FINISH = 3'd5;
    localparam logic [2:0] CMD_SETDIR = 3'd6;

    // Instruction types.
    localparam logic [2:0] T_DELAY  = 3'd0;
    localparam logic [2:0] T_CRUISE = 3'd1;
    localparam logic [2:0] T_ACCEL  = 3'd2;
    localparam logic [2:0] T_DECEL  = 3'd3;
    localparam logic [2:0] T_SWITCH = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DIR_INV  = 3'd0;
    localparam logic [2:0] CFG_SPR      = 3'd1;
    localparam logic [2:0] CFG_MIN_INT  = 3'd2;
    localparam logic [2:0] CFG_MAN_INT  = 3'd3;
    localparam logic [2:0] CFG_DECEL    = 3'd4;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [15:0]       divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [15:0]       remainder;
    } t_div_rsp;

endpackage

/* rtl/smseq_ram.sv */
`timescale 1ns / 1ps
module smseq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/smseq_div.sv */
`timescale 1ns / 1ps
module smseq_div import smseq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    // Restoring divider, one quotient bit per cycle.
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIVD_W-1:0] r_quo;
    logic [15:0]       r_rem;
    logic [15:0]       r_dvs;
    logic [16:0]       rem_sh;
    logic              ge;
    logic [16:0]       rem_nx;

    assign rem_sh = {r_rem, r_quo[DIVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};
    assign rem_nx = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], ge};
            r_rem <= rem_nx[15:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

/* rtl/stepper_motion_sequencer_core.sv */
`timescale 1ns / 1ps
// Clear, curve load, set direction, idle ticks and adds without a move show their result in the
// cycle after acceptance. A position move takes two serial divider passes: an add that moves
// or a manual step runs both before its result, and a run tick that retires a moving
// instruction and loads a decelerating one also runs a curve division and a multiply.
// One item at a time: no new item is taken until the result of the last one has been taken.
// Reset: synchronous, active low; registers and queue state return to their defaults.
module stepper_motion_sequencer_core import smseq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Input item channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_cmd,
    input  logic [2:0]  i_instr_type,
    input  logic [15:0] i_step_count,
    input  logic [15:0] i_speed_us,
    input  logic [31:0] i_now_us,
    input  logic [6:0]  i_curve_index,
    input  logic [15:0] i_curve_value,
    input  logic [15:0] i_target_pos,
    input  logic        i_shortest_way,
    input  logic        i_new_direction,
    // Result channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_step_pulse,
    output logic        o_dir_level,
    output logic        o_finished,
    output logic [15:0] o_current_pos,
    output logic [15:0] o_planned_pos,
    output logic [23:0] o_interval_us,
    output logic        o_queue_full
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_OUT    = 4'd1;
    localparam logic [3:0] S_ADV    = 4'd2;
    localparam logic [3:0] S_ADV2   = 4'd3;
    localparam logic [3:0] S_LOAD   = 4'd4;
    localparam logic [3:0] S_CI     = 4'd5;
    localparam logic [3:0] S_CDIV   = 4'd6;
    localparam logic [3:0] S_CRD    = 4'd7;
    localparam logic [3:0] S_MUL    = 4'd8;
    localparam logic [3:0] S_FLOOR  = 4'd9;
    localparam logic [3:0] S_MOD_P  = 4'd10;
    localparam logic [3:0] S_WAIT_P = 4'd11;
    localparam logic [3:0] S_WAIT_A = 4'd12;

    // Where the result of a position move goes.
    localparam logic [1:0] MV_PLAN = 2'd0;
    localparam logic [1:0] MV_MAN  = 2'd1;
    localparam logic [1:0] MV_ADV  = 2'd2;

    // Configuration registers.
    logic        r_dir_inv;
    logic [15:0] r_spr, r_min, r_man, r_decel;

    // Control and architectural state.
    logic [3:0]      r_state, n_state;
    logic [QC_W-1:0] r_qcount, n_qcount;
    logic [QC_W-1:0] r_next, n_next;
    logic [2:0]      r_atype, n_atype;
    logic [15:0]     r_asteps, n_asteps;
    logic [15:0]     r_aspeed, n_aspeed;
    logic [15:0]     r_left, n_left;
    logic [15:0]     r_sdone, n_sdone;
    logic [23:0]     r_interval, n_interval;
    logic [31:0]     r_last, n_last;
    logic            r_rdir, n_rdir;
    logic            r_pdir, n_pdir;
    logic            r_fin, n_fin;
    logic [15:0]     r_pos, n_pos;
    logic [15:0]     r_ppos, n_ppos;
    logic            r_pulse, n_pulse;
    logic            r_qfull, n_qfull;

    // Working registers of the sequencer.
    logic [23:0] r_val, n_val;
    logic [31:0] r_prod, n_prod;
    logic [15:0] r_mv_pos, n_mv_pos;
    logic [15:0] r_mv_amt, n_mv_amt;
    logic        r_mv_dir, n_mv_dir;
    logic [1:0]  r_mv_dst, n_mv_dst;
    logic [15:0] r_mv_p, n_mv_p;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic              accept;
    logic              q_we;
    logic [QENT_W-1:0] q_wdata, q_rdata;
    logic              c_we;
    logic [CA_W-1:0]   c_raddr;
    logic [15:0]       c_rdata;

    logic [15:0] modv, half;
    logic [2:0]  add_type;
    logic [15:0] add_steps, add_speed;
    logic [31:0] run_elapsed;
    logic        run_due, man_due;
    logic signed [17:0] diff;
    logic        man_dir;
    logic [16:0] mv_sum;
    logic [15:0] mv_res;
    logic [15:0] den;
    logic [15:0] cur_steps;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign accept      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_inv <= 1'b0;
            r_spr     <= 16'd4096;
            r_min     <= 16'd250;
            r_man     <= 16'd500;
            r_decel   <= 16'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DIR_INV: r_dir_inv <= i_cfg_data[0];
                CFG_SPR:     r_spr     <= i_cfg_data;
                CFG_MIN_INT: r_min     <= i_cfg_data;
                CFG_MAN_INT: r_man     <= i_cfg_data;
                CFG_DECEL:   r_decel   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A zero modulus behaves as one.
    assign modv = (r_spr == 16'd0) ? 16'd1 : r_spr;
    assign half = modv >> 1;

    assign add_type  = (i_instr_type > T_SWITCH) ? T_DELAY : i_instr_type;
    assign add_steps = (i_step_count == 16'd0) ? 16'd1 : i_step_count;
    assign add_speed = (i_speed_us == 16'd0) ? 16'd1 : i_speed_us;

    assign run_elapsed = i_now_us - r_last;
    assign run_due     = !r_fin && (run_elapsed >= {8'd0, r_interval});
    assign man_due     = (r_pos != i_target_pos) && (run_elapsed >= {16'd0, r_man});

    // Shortest way round: compare the signed distance with half a revolution.
    assign diff = $signed({2'b00, r_pos}) - $signed({2'b00, i_target_pos});
    always_comb begin
        if (!i_shortest_way) begin
            man_dir = r_rdir;
        end else if (diff > $signed({2'b00, half})) begin
            man_dir = 1'b1;
        end else if (diff < -$signed({2'b00, half})) begin
            man_dir = 1'b0;
        end else if (diff > 18'sd0) begin
            man_dir = 1'b0;
        end else begin
            man_dir = 1'b1;
        end
    end

    // Both operands are already reduced below the modulus here.
    always_comb begin
        if (r_mv_dir) begin
            mv_sum = {1'b0, r_mv_p} + {1'b0, div_rsp.remainder};
            mv_res = (mv_sum >= {1'b0, modv}) ? 16'(mv_sum - {1'b0, modv}) : mv_sum[15:0];
        end else begin
            mv_sum = {1'b0, r_mv_p} + {1'b0, modv} - {1'b0, div_rsp.remainder};
            mv_res = (r_mv_p >= div_rsp.remainder) ? (r_mv_p - div_rsp.remainder)
                                                   : mv_sum[15:0];
        end
    end

    assign den       = (r_asteps == 16'd0) ? 16'd1 : r_asteps;
    assign cur_steps = (r_atype == T_ACCEL) ? r_sdone : r_left;

    assign q_we    = accept && (i_cmd == CMD_ADD) && (r_qcount < QC_W'(QUEUE_DEPTH));
    assign q_wdata = {add_type, add_steps, add_speed};
    assign c_we    = accept && (i_cmd == CMD_CURVE) && (32'(i_curve_index) < CURVE_LEN);

    // Curve index capped at the last entry.
    assign c_raddr = (div_rsp.quotient > DIVD_W'(CURVE_LEN - 1)) ? CA_W'(CURVE_LEN - 1)
                                                                 : CA_W'(div_rsp.quotient);

    always_comb begin
        n_state    = r_state;
        n_qcount   = r_qcount;
        n_next     = r_next;
        n_atype    = r_atype;
        n_asteps   = r_asteps;
        n_aspeed   = r_aspeed;
        n_left     = r_left;
        n_sdone    = r_sdone;
        n_interval = r_interval;
        n_last     = r_last;
        n_rdir     = r_rdir;
        n_pdir     = r_pdir;
        n_fin      = r_fin;
        n_pos      = r_pos;
        n_ppos     = r_ppos;
        n_pulse    = r_pulse;
        n_qfull    = r_qfull;
        n_val      = r_val;
        n_prod     = r_prod;
        n_mv_pos   = r_mv_pos;
        n_mv_amt   = r_mv_amt;
        n_mv_dir   = r_mv_dir;
        n_mv_dst   = r_mv_dst;
        n_mv_p     = r_mv_p;
        div_req.start    = 1'b0;
        div_req.dividend = {(DIVD_W-16)'(0), r_mv_pos};
        div_req.divisor  = modv;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pulse = 1'b0;
                    n_qfull = 1'b0;
                    n_state = S_OUT;
                    case (i_cmd)
                        CMD_ADD: begin
                            if (r_qcount >= QC_W'(QUEUE_DEPTH)) begin
                                n_qfull = 1'b1;
                            end else begin
                                n_qcount = r_qcount + 1'b1;
                                n_fin    = 1'b0;
                                if (add_type == T_SWITCH) begin
                                    n_pdir = !r_pdir;
                                end else if (add_type != T_DELAY) begin
                                    n_mv_pos = r_ppos;
                                    n_mv_amt = add_steps;
                                    n_mv_dir = r_pdir;
                                    n_mv_dst = MV_PLAN;
                                    n_state  = S_MOD_P;
                                end
                            end
                        end
                        CMD_RUN: begin
                            if (run_due) begin
                                n_last = i_now_us;
                                if (r_left == 16'd0) begin
                                    n_state = S_ADV;
                                end else begin
                                    n_pulse = (r_atype != T_DELAY) && (r_atype != T_SWITCH);
                                    n_left  = r_left - 1'b1;
                                    n_sdone = r_sdone + 1'b1;
                                    n_state = (r_left == 16'd1) ? S_ADV : S_CI;
                                end
                            end
                        end
                        CMD_CLEAR, CMD_FINISH: begin
                            n_ppos     = r_pos;
                            n_fin      = 1'b1;
                            n_qcount   = '0;
                            n_next     = '0;
                            n_atype    = T_DELAY;
                            n_left     = '0;
                            n_sdone    = '0;
                            n_interval = '0;
                            n_last     = '0;
                        end
                        CMD_MANUAL: begin
                            if (man_due) begin
                                n_rdir   = man_dir;
                                n_pdir   = man_dir;
                                n_pulse  = 1'b1;
                                n_last   = i_now_us;
                                n_mv_pos = r_pos;
                                n_mv_amt = 16'd1;
                                n_mv_dir = man_dir;
                                n_mv_dst = MV_MAN;
                                n_state  = S_MOD_P;
                            end
                        end
                        CMD_SETDIR: begin
                            n_rdir = i_new_direction;
                            n_pdir = i_new_direction;
                        end
                        default: ;
                    endcase
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            // Retire the active instruction.
            S_ADV: begin
                n_sdone = '0;
                if (r_atype == T_SWITCH) begin
                    n_rdir  = !r_rdir;
                    n_pdir  = !r_rdir;
                    n_state = S_ADV2;
                end else if (r_atype != T_DELAY) begin
                    n_mv_pos = r_pos;
                    n_mv_amt = r_sdone;
                    n_mv_dir = r_rdir;
                    n_mv_dst = MV_ADV;
                    n_state  = S_MOD_P;
                end else begin
                    n_state = S_ADV2;
                end
            end
            // The queue memory reads at r_next in this cycle.
            S_ADV2: begin
                if (r_next >= r_qcount) begin
                    n_ppos     = r_pos;
                    n_fin      = 1'b1;
                    n_qcount   = '0;
                    n_next     = '0;
                    n_atype    = T_DELAY;
                    n_left     = '0;
                    n_sdone    = '0;
                    n_interval = '0;
                    n_last     = '0;
                    n_state    = S_OUT;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_atype  = q_rdata[QENT_W-1 -: 3];
                n_asteps = q_rdata[31:16];
                n_aspeed = q_rdata[15:0];
                n_left   = q_rdata[31:16];
                n_next   = r_next + 1'b1;
                n_state  = S_CI;
            end
            S_CI: begin
                case (r_atype)
                    T_DELAY: begin
                        n_val   = {8'd0, r_aspeed};
                        n_state = S_FLOOR;
                    end
                    T_CRUISE: begin
                        n_val   = {8'd0, r_aspeed} + 24'd4;
                        n_state = S_FLOOR;
                    end
                    T_ACCEL, T_DECEL: begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIVD_W'(cur_steps * CURVE_LEN);
                        div_req.divisor  = den;
                        n_state          = S_CDIV;
                    end
                    default: begin
                        n_val   = '0;
                        n_state = S_FLOOR;
                    end
                endcase
            end
            S_CDIV: begin
                if (div_rsp.done) begin
                    n_state = S_CRD;
                end
            end
            S_CRD: begin
                if (r_atype == T_ACCEL) begin
                    n_val   = {8'd0, c_rdata};
                    n_state = S_FLOOR;
                end else begin
                    n_prod  = c_rdata * r_decel;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_val   = r_prod[31:8];
                n_state = S_FLOOR;
            end
            S_FLOOR: begin
                n_interval = (r_val < {8'd0, r_min}) ? {8'd0, r_min} : r_val;
                n_state    = S_OUT;
            end
            // Position move: reduce the position, then the amount, then add or subtract.
            S_MOD_P: begin
                div_req.start = 1'b1;
                n_state       = S_WAIT_P;
            end
            S_WAIT_P: begin
                if (div_rsp.done) begin
                    n_mv_p           = div_rsp.remainder;
                    div_req.start    = 1'b1;
                    div_req.dividend = {(DIVD_W-16)'(0), r_mv_amt};
                    n_state          = S_WAIT_A;
                end
            end
            S_WAIT_A: begin
                if (div_rsp.done) begin
                    case (r_mv_dst)
                        MV_PLAN: begin
                            n_ppos  = mv_res;
                            n_state = S_OUT;
                        end
                        MV_MAN: begin
                            n_pos   = mv_res;
                            n_ppos  = mv_res;
                            n_state = S_OUT;
                        end
                        default: begin
                            n_pos   = mv_res;
                            n_state = S_ADV2;
                        end
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_qcount   <= '0;
            r_next     <= '0;
            r_atype    <= T_DELAY;
            r_asteps   <= '0;
            r_aspeed   <= '0;
            r_left     <= '0;
            r_sdone    <= '0;
            r_interval <= '0;
            r_last     <= '0;
            r_rdir     <= 1'b0;
            r_pdir     <= 1'b0;
            r_fin      <= 1'b1;
            r_pos      <= '0;
            r_ppos     <= '0;
            r_pulse    <= 1'b0;
            r_qfull    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_qcount   <= n_qcount;
            r_next     <= n_next;
            r_atype    <= n_atype;
            r_asteps   <= n_asteps;
            r_aspeed   <= n_aspeed;
            r_left     <= n_left;
            r_sdone    <= n_sdone;
            r_interval <= n_interval;
            r_last     <= n_last;
            r_rdir     <= n_rdir;
            r_pdir     <= n_pdir;
            r_fin      <= n_fin;
            r_pos      <= n_pos;
            r_ppos     <= n_ppos;
            r_pulse    <= n_pulse;
            r_qfull    <= n_qfull;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val    <= n_val;
        r_prod   <= n_prod;
        r_mv_pos <= n_mv_pos;
        r_mv_amt <= n_mv_amt;
        r_mv_dir <= n_mv_dir;
        r_mv_dst <= n_mv_dst;
        r_mv_p   <= n_mv_p;
    end

    smseq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Instruction queue: type, step count and speed in one word.
    smseq_ram #(.WIDTH(QENT_W), .DEPTH(QUEUE_DEPTH), .AW(QA_W)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_qcount[QA_W-1:0]),
        .i_wdata (q_wdata),
        .i_raddr (r_next[QA_W-1:0]),
        .o_rdata (q_rdata)
    );

    // Acceleration curve.
    smseq_ram #(.WIDTH(16), .DEPTH(CURVE_LEN), .AW(CA_W)) u_curve (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (CA_W'(i_curve_index)),
        .i_wdata (i_curve_value),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    // The result fields read the architectural state directly; it holds while the
    // item waits.
    assign o_valid       = (r_state == S_OUT);
    assign o_step_pulse  = r_pulse;
    assign o_dir_level   = r_rdir ^ r_dir_inv;
    assign o_finished    = r_fin;
    assign o_current_pos = r_pos;
    assign o_planned_pos = r_ppos;
    assign o_interval_us = r_interval;
    assign o_queue_full  = r_qfull;

endmodule

/* rtl/smseq_chk.sv */
`timescale 1ns / 1ps
module smseq_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_step_pulse,
    input logic        o_finished,
    input logic [15:0] o_current_pos,
    input logic [23:0] o_interval_us,
    input logic        o_queue_full
);

    // One item at a time: never ready while a result is shown.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready while a result is pending");

    // A rejected add never carries a step pulse.
    a_full_no_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_queue_full |-> !o_step_pulse)
        else $error("pulse on a rejected add");

    // With no sequence running the run interval is cleared.
    a_fin_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_finished |-> o_interval_us == 24'd0)
        else $error("interval set while finished");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_current_pos))
        else $error("result changed while stalled");

endmodule

bind stepper_motion_sequencer_core smseq_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_step_pulse  (o_step_pulse),
    .o_finished    (o_finished),
    .o_current_pos (o_current_pos),
    .o_interval_us (o_interval_us),
    .o_queue_full  (o_queue_full)
);

/* tb/sv/stepper_motion_sequencer_core_test.sv */
`timescale 1ns / 1ps
module stepper_motion_sequencer_core_test;
    import smseq_pkg::*;

    // Cycles without any accepted item before the run is declared hung.
    localparam int STALL_LIMIT = 20000;
    // Cycles of quiet after the last result, well above the longest latency.
    localparam int TAIL_CYCLES = 200;

    // One input item as seen on the payload ports.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  typ;
        logic [15:0] steps;
        logic [15:0] speed;
        logic [31:0] now;
        logic [6:0]  cidx;
        logic [15:0] cval;
        logic [15:0] tgt;
        logic        shortest;
        logic        ndir;
    } motion_item_t;

    // One result item as seen on the output ports.
    typedef struct packed {
        logic        pulse;
        logic        dir;
        logic        fin;
        logic [15:0] cur;
        logic [15:0] plan;
        logic [23:0] intv;
        logic        qfull;
    } motion_result_t;

    // A row of the directed part: the item and, where it can be read off at a
    // glance, the result that it must give.
    typedef struct packed {
        motion_item_t   item;
        logic           typed;
        motion_result_t res;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_cmd;
    logic [2:0]  i_instr_type;
    logic [15:0] i_step_count;
    logic [15:0] i_speed_us;
    logic [31:0] i_now_us;
    logic [6:0]  i_curve_index;
    logic [15:0] i_curve_value;
    logic [15:0] i_target_pos;
    logic        i_shortest_way;
    logic        i_new_direction;
    logic        o_valid;
    logic        i_ready;
    logic        o_step_pulse;
    logic        o_dir_level;
    logic        o_finished;
    logic [15:0] o_current_pos;
    logic [15:0] o_planned_pos;
    logic [23:0] o_interval_us;
    logic        o_queue_full;

    stepper_motion_sequencer_core i_dut (.*);

    always #6 i_clk = ~i_clk;

    // Shadow copy of the configuration registers.
    logic        sh_dir_inv;
    logic [15:0] sh_spr;
    logic [15:0] sh_min_int;
    logic [15:0] sh_man_int;
    logic [15:0] sh_decel;

    // Shadow copy of the sequencer state.
    logic [2:0]  q_type [QUEUE_DEPTH];
    logic [15:0] q_steps [QUEUE_DEPTH];
    logic [15:0] q_speed [QUEUE_DEPTH];
    logic [15:0] curve [CURVE_LEN];
    int          q_fill;
    int          q_next;
    logic [2:0]  act_type;
    logic [15:0] act_steps;
    logic [15:0] act_speed;
    logic [15:0] steps_left;
    logic [15:0] steps_taken;
    logic [23:0] interval;
    logic [31:0] last_time;
    logic        real_dir;
    logic        plan_dir;
    logic        idle;
    logic [15:0] pos;
    logic [15:0] plan_pos;

    // Results that the block still owes, oldest first.
    motion_result_t owed_results[$];

    int n_items;
    int n_results;
    int n_cfg;
    int n_errors;
    int n_pulses;
    int n_rejects;
    int quiet_cycles;
    bit gaps_on;

    // Set by the sender just before it raises valid; read when the item is taken.
    bit             typed_pending;
    motion_result_t typed_result;

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
        n_errors++;
    endtask

    function automatic longint unsigned modulus();
        return (sh_spr == 16'd0) ? 64'd1 : 64'(sh_spr);
    endfunction

    function automatic logic [15:0] move_pos(logic [15:0] p, logic [15:0] amount, logic up);
        longint unsigned m;
        longint unsigned pp;
        longint unsigned a;
        m = modulus();
        pp = 64'(p) % m;
        a = 64'(amount) % m;
        pp = up ? (pp + a) % m : (pp + m - a) % m;
        return pp[15:0];
    endfunction

    function automatic void clear_sequence();
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            q_type[i] = T_DELAY;
            q_steps[i] = '0;
            q_speed[i] = '0;
        end
        plan_pos = pos;
        idle = 1'b1;
        q_fill = 0;
        q_next = 0;
        act_type = T_DELAY;
        steps_left = '0;
        steps_taken = '0;
        interval = '0;
        last_time = '0;
    endfunction

    function automatic longint unsigned curve_at(longint unsigned idx);
        if (idx > CURVE_LEN - 1) idx = CURVE_LEN - 1;
        return 64'(curve[idx]);
    endfunction

    function automatic void next_interval();
        longint unsigned v;
        longint unsigned den;
        den = (act_steps == 16'd0) ? 64'd1 : 64'(act_steps);
        case (act_type)
            T_DELAY:  v = 64'(act_speed);
            T_CRUISE: v = 64'(act_speed) + 64'd4;
            T_ACCEL:  v = curve_at(64'(steps_taken) * CURVE_LEN / den);
            T_DECEL:  v = (curve_at(64'(steps_left) * CURVE_LEN / den) * 64'(sh_decel)) >> 8;
            default:  v = 64'd0;
        endcase
        if (v < 64'(sh_min_int)) v = 64'(sh_min_int);
        if (v > 64'hFF_FFFF) v = 64'hFF_FFFF;
        interval = v[23:0];
    endfunction

    // Retires the active instruction; returns 0 once the queue has run out.
    function automatic bit retire_instruction();
        if (act_type == T_SWITCH) begin
            real_dir = ~real_dir;
            plan_dir = real_dir;
        end else if (act_type != T_DELAY) begin
            pos = move_pos(pos, steps_taken, real_dir);
        end
        steps_taken = '0;
        if (q_next >= q_fill) begin
            clear_sequence();
            return 1'b0;
        end
        act_type = q_type[q_next];
        act_steps = q_steps[q_next];
        act_speed = q_speed[q_next];
        steps_left = act_steps;
        q_next++;
        return 1'b1;
    endfunction

    // Applies one item to the shadow state and returns the result it gives.
    function automatic motion_result_t apply_motion_item(motion_item_t it);
        motion_result_t r;
        logic [2:0]     typ;
        logic [15:0]    stp;
        logic [15:0]    spd;
        logic [31:0]    elapsed;
        longint         diff;
        longint         half;
        logic           d;
        r = '0;
        elapsed = it.now - last_time;
        case (it.cmd)
            CMD_ADD: begin
                if (q_fill >= QUEUE_DEPTH) begin
                    r.qfull = 1'b1;
                end else begin
                    typ = (it.typ > T_SWITCH) ? T_DELAY : it.typ;
                    stp = (it.steps == 16'd0) ? 16'd1 : it.steps;
                    spd = (it.speed == 16'd0) ? 16'd1 : it.speed;
                    q_type[q_fill] = typ;
                    q_steps[q_fill] = stp;
                    q_speed[q_fill] = spd;
                    q_fill++;
                    if (typ == T_SWITCH) plan_dir = ~plan_dir;
                    else if (typ != T_DELAY) plan_pos = move_pos(plan_pos, stp, plan_dir);
                    idle = 1'b0;
                end
            end
            CMD_RUN: begin
                if (!idle && elapsed >= 32'(interval)) begin
                    last_time = it.now;
                    if (steps_left == 16'd0) begin
                        if (retire_instruction()) next_interval();
                    end else begin
                        r.pulse = (act_type != T_DELAY) && (act_type != T_SWITCH);
                        steps_left--;
                        steps_taken++;
                        if (steps_left != 16'd0 || retire_instruction()) next_interval();
                    end
                end
            end
            CMD_CLEAR, CMD_FINISH: clear_sequence();
            CMD_CURVE: begin
                if (it.cidx < CURVE_LEN) curve[it.cidx] = it.cval;
            end
            CMD_MANUAL: begin
                if (pos != it.tgt && elapsed >= 32'(sh_man_int)) begin
                    d = real_dir;
                    if (it.shortest) begin
                        diff = longint'(pos) - longint'(it.tgt);
                        half = longint'(modulus() / 2);
                        if (diff > half) d = 1'b1;
                        else if (diff < -half) d = 1'b0;
                        else if (diff > 0) d = 1'b0;
                        else d = 1'b1;
                    end
                    real_dir = d;
                    plan_dir = d;
                    pos = move_pos(pos, 16'd1, d);
                    plan_pos = pos;
                    r.pulse = 1'b1;
                    last_time = it.now;
                end
            end
            CMD_SETDIR: begin
                real_dir = it.ndir;
                plan_dir = it.ndir;
            end
            default: ;
        endcase
        r.dir = real_dir ^ sh_dir_inv;
        r.fin = idle;
        r.cur = pos;
        r.plan = plan_pos;
        r.intv = interval;
        return r;
    endfunction

    // Monitor: every handshake is seen at the rising edge. Predictions are
    // pushed before results are checked, so an item and its result can never
    // be seen out of order.
    always @(posedge i_clk) begin
        motion_item_t   it;
        motion_result_t got;
        motion_result_t want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DIR_INV: sh_dir_inv = i_cfg_data[0];
                    CFG_SPR:     sh_spr = i_cfg_data;
                    CFG_MIN_INT: sh_min_int = i_cfg_data;
                    CFG_MAN_INT: sh_man_int = i_cfg_data;
                    CFG_DECEL:   sh_decel = i_cfg_data;
                    default: ;
                endcase
                n_cfg++;
            end
            if (i_valid && o_ready) begin
                it = '{i_cmd, i_instr_type, i_step_count, i_speed_us, i_now_us,
                       i_curve_index, i_curve_value, i_target_pos, i_shortest_way,
                       i_new_direction};
                want = apply_motion_item(it);
                if (typed_pending) want = typed_result;
                owed_results.push_back(want);
                n_items++;
            end
            if (o_valid && i_ready) begin
                got = '{o_step_pulse, o_dir_level, o_finished, o_current_pos,
                        o_planned_pos, o_interval_us, o_queue_full};
                n_results++;
                if (owed_results.size() == 0) begin
                    report_mismatch("result with nothing owed", got, 0);
                end else begin
                    want = owed_results.pop_front();
                    if (got.pulse !== want.pulse) report_mismatch("step_pulse", got.pulse, want.pulse);
                    if (got.dir !== want.dir) report_mismatch("dir_level", got.dir, want.dir);
                    if (got.fin !== want.fin) report_mismatch("finished", got.fin, want.fin);
                    if (got.cur !== want.cur) report_mismatch("current_pos", got.cur, want.cur);
                    if (got.plan !== want.plan) report_mismatch("planned_pos", got.plan, want.plan);
                    if (got.intv !== want.intv) report_mismatch("interval_us", got.intv, want.intv);
                    if (got.qfull !== want.qfull) report_mismatch("queue_full", got.qfull, want.qfull);
                    if (got.pulse === 1'b1) n_pulses++;
                    if (got.qfull === 1'b1) n_rejects++;
                end
            end
        end
    end

    // Watchdog: the run is hung when no channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side back-pressure: random stall bursts while gaps are enabled.
    initial begin
        i_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (gaps_on && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
                i_ready <= 1'b1;
            end
        end
    end

    // Presents one item and returns at the falling edge after it was taken.
    task automatic send_item(motion_item_t it, logic typed, motion_result_t res);
        int seen;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_cmd <= it.cmd;
        i_instr_type <= it.typ;
        i_step_count <= it.steps;
        i_speed_us <= it.speed;
        i_now_us <= it.now;
        i_curve_index <= it.cidx;
        i_curve_value <= it.cval;
        i_target_pos <= it.tgt;
        i_shortest_way <= it.shortest;
        i_new_direction <= it.ndir;
        i_valid <= 1'b1;
        typed_pending = typed;
        typed_result = res;
        seen = n_items;
        do @(negedge i_clk); while (n_items == seen);
    endtask

    task automatic send(motion_item_t it);
        send_item(it, 1'b0, '0);
    endtask

    // Lets every owed result come back, then writes all five registers.
    task automatic write_config(logic dinv, logic [15:0] spr, logic [15:0] mn,
                                logic [15:0] man, logic [15:0] dec);
        logic [15:0] vals [5];
        logic [2:0]  idx [5];
        int          seen;
        vals = '{16'(dinv), spr, mn, man, dec};
        idx = '{CFG_DIR_INV, CFG_SPR, CFG_MIN_INT, CFG_MAN_INT, CFG_DECEL};
        i_valid <= 1'b0;
        while (owed_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        for (int k = 0; k < 5; k++) begin
            i_cfg_index <= idx[k];
            i_cfg_data <= vals[k];
            i_cfg_valid <= 1'b1;
            seen = n_cfg;
            do @(negedge i_clk); while (n_cfg == seen);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic motion_item_t make_item(logic [2:0] cmd);
        motion_item_t it;
        it = '0;
        it.cmd = cmd;
        return it;
    endfunction

    function automatic motion_item_t noise_item();
        motion_item_t it;
        it = '{3'($urandom_range(0, 7)), 3'($urandom), 16'($urandom), 16'($urandom),
               $urandom, 7'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
               1'($urandom)};
        return it;
    endfunction

    // A well-formed program: optional clear and direction, a burst of adds
    // (sometimes more than the queue holds), then run ticks until it ends or is finished by force.
    task automatic run_program();
        motion_item_t it;
        int           n_add;
        int           ticks;
        int           pick;
        if ($urandom_range(0, 1)) send(make_item(CMD_CLEAR));
        if ($urandom_range(0, 3) == 0) begin
            it = make_item(CMD_SETDIR);
            it.ndir = 1'($urandom);
            send(it);
        end
        n_add = $urandom_range(1, 18);
        repeat (n_add) begin
            it = make_item(CMD_ADD);
            pick = $urandom_range(0, 99);
            it.typ = (pick < 92) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
            pick = $urandom_range(0, 99);
            if (pick < 85) it.steps = 16'($urandom_range(1, 12));
            else if (pick < 92) it.steps = 16'd0;
            else it.steps = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 85) it.speed = 16'($urandom_range(1, 2000));
            else if (pick < 92) it.speed = 16'd0;
            else it.speed = 16'($urandom);
            send(it);
        end
        ticks = 0;
        while (!idle && ticks < 80) begin
            it = make_item(CMD_RUN);
            if ($urandom_range(0, 6) == 0)
                it.now = last_time + 32'($urandom_range(0, int'(interval)));
            else
                it.now = last_time + 32'(interval) + 32'($urandom_range(0, 3));
            send(it);
            ticks++;
        end
        if (!idle) send(make_item(CMD_FINISH));
    endtask

    task automatic manual_burst();
        motion_item_t it;
        repeat ($urandom_range(1, 8)) begin
            it = make_item(CMD_MANUAL);
            it.tgt = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, int'(sh_spr)));
            it.shortest = 1'($urandom);
            if ($urandom_range(0, 5) == 0)
                it.now = last_time + 32'($urandom_range(0, int'(sh_man_int)));
            else
                it.now = last_time + 32'(sh_man_int) + 32'($urandom_range(0, 2));
            send(it);
        end
    endtask

    task automatic random_phase(int n);
        int stop_at;
        int pick;
        stop_at = n_items + n;
        while (n_items < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) run_program();
            else if (pick < 87) manual_burst();
            else send(noise_item());
        end
    endtask

    initial begin
        stim_row_t      rows[$];
        stim_row_t      row;
        motion_item_t   it;
        motion_result_t idle_res;
        int             wait_cycles;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DIR_INV;
        i_cfg_data = '0;
        i_valid = 1'b0;
        {i_cmd, i_instr_type, i_step_count, i_speed_us, i_now_us, i_curve_index,
         i_curve_value, i_target_pos, i_shortest_way, i_new_direction} = '0;
        typed_pending = 1'b0;
        typed_result = '0;
        gaps_on = 1'b1;
        n_items = 0;
        n_results = 0;
        n_cfg = 0;
        n_errors = 0;
        n_pulses = 0;
        n_rejects = 0;
        quiet_cycles = 0;

        // Shadow state starts at the block's reset values.
        sh_dir_inv = 1'b0;
        sh_spr = 16'd4096;
        sh_min_int = 16'd250;
        sh_man_int = 16'd500;
        sh_decel = 16'd256;
        for (int i = 0; i < CURVE_LEN; i++) curve[i] = '0;
        pos = '0;
        real_dir = 1'b0;
        plan_dir = 1'b0;
        act_steps = '0;
        act_speed = '0;
        clear_sequence();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Right after reset, before anything touches the position: an idle run
        // tick, the direction set, an ignored curve slot and the unused command
        // must all leave the block at rest.
        idle_res = '{1'b0, 1'b0, 1'b1, 16'd0, 16'd0, 24'd0, 1'b0};
        send_item(make_item(CMD_RUN), 1'b1, idle_res);
        it = make_item(CMD_SETDIR);
        it.ndir = 1'b1;
        idle_res.dir = 1'b1;
        send_item(it, 1'b1, idle_res);
        it = make_item(CMD_CURVE);
        it.cidx = 7'd127;
        it.cval = 16'hFFFF;
        send_item(it, 1'b1, idle_res);
        send_item(make_item(3'd7), 1'b1, idle_res);

        // The whole curve is written before any instruction can read it, with
        // both value extremes at its two ends.
        for (int i = 0; i < CURVE_LEN; i++) begin
            it = make_item(CMD_CURVE);
            it.cidx = 7'(i);
            if (i == 0) it.cval = 16'd0;
            else if (i == CURVE_LEN - 1) it.cval = 16'hFFFF;
            else it.cval = 16'($urandom_range(1, 3000));
            send(it);
        end

        // Directed rows: manual steps both ways and by the shortest way, every
        // instruction type including an unknown one, zero counts and speeds,
        // a sequence run through its start and a direction switch, a time wrap,
        // then a huge instruction cut off by force finish.
        it = make_item(CMD_MANUAL); it.tgt = 16'd3; it.now = 32'd1000;
        rows.push_back('{it, 1'b0, '0});
        it.tgt = 16'hFFFF; it.shortest = 1'b1; it.now = 32'd2000;
        rows.push_back('{it, 1'b0, '0});
        it.tgt = 16'd0; it.now = 32'd3000;
        rows.push_back('{it, 1'b0, '0});
        it = make_item(CMD_ADD); it.typ = T_CRUISE;
        rows.push_back('{it, 1'b0, '0});
        it.typ = T_ACCEL; it.steps = 16'd3; it.speed = 16'd10;
        rows.push_back('{it, 1'b0, '0});
        it.typ = T_SWITCH;
        rows.push_back('{it, 1'b0, '0});
        it.typ = T_DECEL; it.steps = 16'd2;
        rows.push_back('{it, 1'b0, '0});
        it.typ = 3'd7; it.steps = 16'd1; it.speed = 16'hFFFF;
        rows.push_back('{it, 1'b0, '0});
        for (int k = 1; k <= 11; k++) begin
            it = make_item(CMD_RUN);
            it.now = (k == 11) ? 32'hFFFF_FFFF : 32'(k) << 20;
            rows.push_back('{it, 1'b0, '0});
        end
        it = make_item(CMD_ADD); it.typ = T_CRUISE;
        it.steps = 16'hFFFF; it.speed = 16'hFFFF;
        rows.push_back('{it, 1'b0, '0});
        rows.push_back('{make_item(CMD_RUN), 1'b0, '0});
        rows.push_back('{make_item(CMD_FINISH), 1'b0, '0});
        rows.push_back('{make_item(CMD_CLEAR), 1'b0, '0});
        foreach (rows[k]) begin
            row = rows[k];
            send_item(row.item, row.typed, row.res);
        end

        // Random phases, each under its own settings. Draining for the
        // register writes also makes the sender wait for every owed result.
        random_phase(300);
        write_config(1'b1, 16'd1, 16'd0, 16'd0, 16'hFFFF);
        random_phase(300);
        write_config(1'b0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        random_phase(250);
        write_config(1'b1, 16'hFFFF, 16'd10, 16'd1, 16'd384);
        random_phase(300);
        write_config(1'b0, 16'($urandom_range(2, 5000)), 16'($urandom_range(0, 300)),
                     16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1024)));
        // The last stretch runs with neither side idling.
        gaps_on = 1'b0;
        random_phase(350);

        i_valid <= 1'b0;
        while (owed_results.size() != 0) @(negedge i_clk);
        wait_cycles = 0;
        while (wait_cycles < TAIL_CYCLES) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        if (owed_results.size() != 0) report_mismatch("results left owed", owed_results.size(), 0);

        $display("covered %0d items and %0d results over five register settings,", n_items,
                 n_results);
        $display("with %0d step pulses and %0d rejected adds on a full queue", n_pulses,
                 n_rejects);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
